// ----- sv/fbpa_pkg.sv -----
package fbpa_pkg;

  localparam int unsigned DefMaxBlocks = 1024;
  localparam int unsigned DefAddrBits  = 32;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned BaseW      = 32;
  localparam int unsigned SizeW      = 16;
  localparam int unsigned CountCfgW  = 11;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned FreeCountW = 11;

  localparam logic [CfgIdxW-1:0] CFG_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd2;

  localparam logic [BaseW-1:0]     RstBase  = 32'd0;
  localparam logic [SizeW-1:0]     RstSize  = 16'd64;
  localparam logic [CountCfgW-1:0] RstCount = 11'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STS_ALLOCATED  = 3'd0,
    STS_EMPTY      = 3'd1,
    STS_FREED      = 3'd2,
    STS_OUTSIDE    = 3'd3,
    STS_MISALIGNED = 3'd4,
    STS_ALL_FREE   = 3'd5
  } status_e;

endpackage

// ----- sv/fbpa_ram.sv -----
module fbpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fixed_block_pool_allocator.sv -----
// Fixed-size block pool with a LIFO free list of block addresses.
// Request channel (in_valid_i / in_stall_o) carries one word: cmd_i selects
// allocate or free, address_i is the block to free. Result channel
// (out_valid_o / out_stall_i) returns status, the allocated address and the
// free count after the request. One request is in flight at a time.
// Allocate: stack RAM read (S_READ), then select (S_ALLOC); an empty pool
// answers from S_READ. Free: range check (S_CHECK), then the restoring
// remainder unit in S_DIV, which takes one quotient bit per cycle, then
// the push (S_PUSH); an address outside the region answers from S_CHECK.
// A new request is taken the cycle after the previous result is registered,
// even while that result still waits on out_stall_i; a later result holds
// in its final step until the output register is free.
// Reset and every config write to base, size or count rebuild the pool at
// once: all blocks free, last block on top. Stack entries never pushed since
// the rebuild read as their computed address, so there is no clearing pass.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks,
  parameter int unsigned ADDR_BITS  = DefAddrBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [ADDR_BITS-1:0]  address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [StatusW-1:0]    status_o,
  output logic [ADDR_BITS-1:0]  block_address_o,
  output logic [FreeCountW-1:0] free_count_o
);

  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LimW  = SizeW + CntW;
  localparam int unsigned KW    = (IdxW > 1) ? $clog2(IdxW) : 1;
  localparam int unsigned CmpW  = ADDR_BITS + LimW;
  localparam logic [CntW-1:0] CountMax = CntW'(MAX_BLOCKS);
  localparam logic [CntW-1:0] CountRst =
      (RstCount > MAX_BLOCKS) ? CntW'(MAX_BLOCKS) : CntW'(RstCount);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ALLOC,
    S_CHECK,
    S_DIV,
    S_PUSH
  } state_e;

  state_e state_q, state_d;

  // configuration, held as effective values
  logic [BaseW-1:0] base_q;
  logic [SizeW-1:0] size_q;
  logic [CntW-1:0]  count_q;

  logic [CntW-1:0] free_q, free_d;
  logic [CntW-1:0] low_q, low_d;   // lowest stack index pushed since rebuild
  logic            out_valid_q, out_valid_d;

  logic [ADDR_BITS-1:0]  addr_q;
  logic [LimW-1:0]       rem_q, rem_d;
  logic [KW-1:0]         k_q, k_d;
  logic [LimW-1:0]       prod_q;
  logic [LimW-1:0]       limit_q;
  logic [StatusW-1:0]    status_q, status_d;
  logic [ADDR_BITS-1:0]  baddr_q, baddr_d;
  logic [FreeCountW-1:0] fcount_q, fcount_d;

  logic                        ram_we, ram_re;
  logic [ADDR_BITS-1:0]        ram_rdata;
  logic [CntW-1:0]             cnt_m1;
  logic [ADDR_BITS-1:0]        base_eff;
  logic [ADDR_BITS+BaseW-1:0]  base_ext;
  logic [ADDR_BITS+LimW-1:0]   prod_ext;
  logic [ADDR_BITS-1:0]        alloc_addr;
  logic [ADDR_BITS-1:0]        offset;
  logic [CmpW-1:0]             offset_ext, limit_ext;
  logic [LimW-1:0]             divisor;
  logic [CntW+FreeCountW-1:0]  fcount_ext;
  logic [CntW+CountCfgW-1:0]   cnt_cfg_ext;
  logic [CntW-1:0]             cnt_cfg_eff;
  logic [CntW-1:0]             rebuild_count;
  logic                        cfg_hit;
  logic                        out_free;

  assign base_ext   = {{ADDR_BITS{1'b0}}, base_q};
  assign base_eff   = base_ext[ADDR_BITS-1:0];
  assign cnt_m1     = free_q - CntW'(1);
  assign prod_ext   = {{ADDR_BITS{1'b0}}, prod_q};
  assign alloc_addr = base_eff + prod_ext[ADDR_BITS-1:0];
  assign offset     = addr_q - base_eff;
  assign offset_ext = {{LimW{1'b0}}, offset};
  assign limit_ext  = {{ADDR_BITS{1'b0}}, limit_q};
  assign divisor    = LimW'(size_q) << k_q;
  assign fcount_ext = {{FreeCountW{1'b0}}, free_d};
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cnt_cfg_ext = {{CntW{1'b0}}, cfg_wdata_i[CountCfgW-1:0]};
  assign cnt_cfg_eff = (cnt_cfg_ext > (CntW + CountCfgW)'(MAX_BLOCKS)) ?
                       CountMax : cnt_cfg_ext[CntW-1:0];
  assign cfg_hit     = cfg_we_i &&
                       (cfg_idx_i == CFG_BASE || cfg_idx_i == CFG_SIZE ||
                        cfg_idx_i == CFG_COUNT);
  assign rebuild_count = (cfg_idx_i == CFG_COUNT) ? cnt_cfg_eff : count_q;

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    low_d       = low_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    baddr_d     = baddr_q;
    rem_d       = rem_q;
    k_d         = k_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd_i == CMD_FREE) ? S_CHECK : S_READ;
        end
      end
      S_READ: begin
        if (free_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            status_d    = STS_EMPTY;
            baddr_d     = '0;
            state_d     = S_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          free_d      = cnt_m1;
          out_valid_d = 1'b1;
          status_d    = STS_ALLOCATED;
          // untouched entries still read as their rebuild address
          baddr_d     = (low_q <= cnt_m1) ? ram_rdata : alloc_addr;
          state_d     = S_IDLE;
        end
      end
      S_CHECK: begin
        if (addr_q < base_eff || offset_ext >= limit_ext) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            status_d    = STS_OUTSIDE;
            baddr_d     = '0;
            state_d     = S_IDLE;
          end
        end else begin
          rem_d   = offset_ext[LimW-1:0];
          k_d     = KW'(IdxW - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_q >= divisor) begin
          rem_d = rem_q - divisor;
        end
        if (k_q == '0) begin
          state_d = S_PUSH;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          baddr_d     = '0;
          state_d     = S_IDLE;
          if (rem_q != '0) begin
            status_d = STS_MISALIGNED;
          end else if (free_q >= count_q) begin
            status_d = STS_ALL_FREE;
          end else begin
            ram_we   = 1'b1;
            free_d   = free_q + CntW'(1);
            low_d    = (free_q < low_q) ? free_q : low_q;
            status_d = STS_FREED;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fcount_d = fcount_ext[FreeCountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= RstBase;
      size_q      <= RstSize;
      count_q     <= CountRst;
      free_q      <= CountRst;
      low_q       <= CountMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_hit) begin
        free_q <= rebuild_count;
        low_q  <= CountMax;
      end else begin
        free_q <= free_d;
        low_q  <= low_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:  base_q  <= cfg_wdata_i[BaseW-1:0];
          CFG_SIZE:  size_q  <= (cfg_wdata_i[SizeW-1:0] == '0) ?
                                SizeW'(1) : cfg_wdata_i[SizeW-1:0];
          CFG_COUNT: count_q <= cnt_cfg_eff;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q  <= LimW'(size_q) * LimW'(count_q);
    rem_q    <= rem_d;
    k_q      <= k_d;
    status_q <= status_d;
    baddr_q  <= baddr_d;
    if (out_valid_d && !(out_valid_q && out_stall_i)) begin
      fcount_q <= fcount_d;
    end
    if (state_q == S_IDLE && in_valid_i) begin
      addr_q <= address_i;
    end
    if (state_q == S_READ) begin
      prod_q <= LimW'(size_q) * LimW'(cnt_m1);
    end
  end

  fbpa_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_q[IdxW-1:0]),
    .wdata_i (addr_q),
    .re_i    (ram_re),
    .raddr_i (cnt_m1[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = baddr_q;
  assign free_count_o    = fcount_q;

endmodule

// ----- sv/fbpa_checker.sv -----
module fbpa_checker
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks,
  parameter int unsigned ADDR_BITS  = DefAddrBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [StatusW-1:0]    status_o,
  input logic [ADDR_BITS-1:0]  block_address_o,
  input logic [FreeCountW-1:0] free_count_o
);

  localparam logic [FreeCountW-1:0] CountTop = FreeCountW'(MAX_BLOCKS);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(block_address_o) && $stable(free_count_o))
    else $error("stalled result changed");

  // only an allocation returns an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_ALLOCATED |-> block_address_o == '0)
    else $error("address on a non-allocate result");

  // a successful free leaves at least one block free
  a_freed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_FREED |-> free_count_o != '0)
    else $error("free count zero after free");

  // never more free blocks than the stack holds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_count_o <= CountTop)
    else $error("free count above stack depth");

  // one request in flight: an accepted word makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS),
  .ADDR_BITS  (ADDR_BITS)
) u_fbpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .block_address_o (block_address_o),
  .free_count_o    (free_count_o)
);
